>>> rtl/rtw_pkg.sv
// Package for the radial twirl point warp block: CORDIC vector and sideband
// types, the arctangent table and fixed constants. No dependencies.
package rtw_pkg;

    localparam int CW        = 28;   // internal coordinate width, Q12.12 plus growth
    localparam int ZW        = 32;   // angle width, Q0.32 turns
    localparam int TABLE_LEN = 24;

    // configuration register indexes
    localparam logic [1:0] REG_ROTATION = 2'd0;
    localparam logic [1:0] REG_INV_LEN  = 2'd1;

    // 1/K in Q2.30
    localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

    // reciprocals of 45 for the angle scaling
    localparam logic [31:0] DIV45_M37 = 32'd3054198967;
    localparam logic [24:0] DIV45_M30 = 25'd23860930;
    localparam logic [16:0] DIV45_M22 = 17'd93207;
    localparam logic [5:0]  DIV45     = 6'd45;

    localparam logic [23:0] WEIGHT_MAX = 24'hFF0000;
    localparam logic [31:0] HALF_TURN  = 32'h80000000;
    localparam logic [31:0] QTR_TURN   = 32'h40000000;
    localparam logic [31:0] TQTR_TURN  = 32'hC0000000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ZW-1:0]        z;
    } rtw_vec_t;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 zero;
        logic [15:0]          hue;
    } rtw_side_t;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] r;
        case (idx)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051E;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2F;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2F9;
            15:      r = 32'h0000517D;
            16:      r = 32'h000028BE;
            17:      r = 32'h0000145F;
            18:      r = 32'h00000A30;
            19:      r = 32'h00000518;
            20:      r = 32'h0000028C;
            21:      r = 32'h00000146;
            22:      r = 32'h000000A3;
            23:      r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/rtw_cordic_cell.sv
// One CORDIC micro-rotation cell, vectoring or rotating mode.
// Depends on rtw_pkg.
module rtw_cordic_cell #(
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  rtw_pkg::rtw_vec_t  in_vec,
    input  rtw_pkg::rtw_side_t in_side,
    output logic              out_valid,
    output rtw_pkg::rtw_vec_t  out_vec,
    output rtw_pkg::rtw_side_t out_side
);

    logic signed [rtw_pkg::CW-1:0] x_in;
    logic signed [rtw_pkg::CW-1:0] y_in;
    logic signed [rtw_pkg::CW-1:0] dx;
    logic signed [rtw_pkg::CW-1:0] dy;
    logic                          pos;
    logic [31:0]                   atan;
    rtw_pkg::rtw_vec_t             vec_next;
    rtw_pkg::rtw_vec_t             vec_reg;
    rtw_pkg::rtw_side_t            side_reg;
    logic                          valid_reg;

    always_comb
    begin
        x_in = $signed(in_vec.x);
        y_in = $signed(in_vec.y);
        dx   = y_in >>> STAGE;
        dy   = x_in >>> STAGE;
        // pos: angle accumulator steps up
        pos  = VECTORING ? ~y_in[rtw_pkg::CW-1] : in_vec.z[31];
        atan = rtw_pkg::atan_turns(STAGE);
        vec_next.x = pos ? (x_in + dx) : (x_in - dx);
        vec_next.y = pos ? (y_in - dy) : (y_in + dy);
        vec_next.z = pos ? (in_vec.z + atan) : (in_vec.z - atan);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/rtw_twirl_angle.sv
// Radius, weight and twirl angle pipeline between the two CORDIC chains.
// Depends on rtw_pkg.
module rtw_twirl_angle (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic signed [31:0]           rotation_degrees,
    input  logic [23:0]                  inv_max_length,
    input  logic                         in_valid,
    input  logic signed [rtw_pkg::CW-1:0] in_vx,
    input  logic [31:0]                  in_phase,
    input  rtw_pkg::rtw_side_t            in_side,
    output logic                         out_valid,
    output rtw_pkg::rtw_vec_t             out_vec,
    output rtw_pkg::rtw_side_t            out_side
);

    localparam int DEPTH = 8;

    // config-derived terms: |deg| = 45*a + b
    logic [31:0]  abs_reg;
    logic         neg_reg;
    logic [63:0]  pa_reg;
    logic [31:0]  abs2_reg;
    logic         neg2_reg;
    logic [25:0]  a_reg;
    logic [5:0]   b_reg;
    logic         neg3_reg;
    logic [26:0]  a0;
    logic [32:0]  a45;
    logic [33:0]  b0;

    // item pipeline
    logic                          vld_reg [0:DEPTH-1];
    rtw_pkg::rtw_side_t            sd_reg  [0:DEPTH-1];
    rtw_pkg::rtw_side_t            side0;
    logic signed [rtw_pkg::CW+31:0] p1_reg;
    logic [27:0]                   rad;
    logic [51:0]                   p2_reg;
    logic [34:0]                   wide;
    logic [23:0]                   w3_reg;
    logic [48:0]                   pc_reg;
    logic [23:0]                   w4_reg;
    logic [18:0]                   c0;
    logic [24:0]                   c45;
    logic [25:0]                   d0;
    logic [18:0]                   c5_reg;
    logic [5:0]                    d5_reg;
    logic [23:0]                   w5_reg;
    logic [49:0]                   aw_full;
    logic [26:0]                   aw6_reg;
    logic [24:0]                   bc6_reg;
    logic [11:0]                   bd6_reg;
    logic [33:0]                   qp;
    logic [31:0]                   mag;
    logic [31:0]                   delta7_reg;
    rtw_pkg::rtw_vec_t             vec_next;
    rtw_pkg::rtw_vec_t             vec8_reg;

    // free-running split of the twirl angle by 45
    always_comb
    begin
        a0  = pa_reg[63:37];
        a45 = a0 * rtw_pkg::DIV45;
        b0  = {2'b00, abs2_reg} - {1'b0, a45};
    end

    always_ff @(posedge clk)
    begin
        abs_reg  <= rotation_degrees[31] ? (32'd0 - rotation_degrees) : rotation_degrees;
        neg_reg  <= rotation_degrees[31];
        pa_reg   <= abs_reg * rtw_pkg::DIV45_M37;
        abs2_reg <= abs_reg;
        neg2_reg <= neg_reg;
        neg3_reg <= neg2_reg;
        if (b0[33])
        begin
            a_reg <= a0[25:0] - 26'd1;
            b_reg <= b0[5:0] + rtw_pkg::DIV45;
        end
        else
        begin
            a_reg <= a0[25:0];
            b_reg <= b0[5:0];
        end
    end

    always_comb
    begin
        side0     = in_side;
        side0.hue = 16'((33'(in_phase) + 33'h8000) >> 16);
        rad       = p1_reg[rtw_pkg::CW+31] ? 28'd0 : p1_reg[57:30];
        wide      = 35'd65536 + {1'b0, p2_reg[51:20], 2'b00};
        c0        = pc_reg[48:30];
        c45       = c0 * rtw_pkg::DIV45;
        d0        = {2'b00, w4_reg} - {1'b0, c45};
        aw_full   = a_reg * w5_reg;
        qp        = {bd6_reg, 5'b00000} * rtw_pkg::DIV45_M22;
        mag       = {aw6_reg, 5'b00000} + {2'b00, bc6_reg, 5'b00000} + {20'd0, qp[33:22]};
        // fold the left half plane onto the right one
        vec_next.x = sd_reg[6].px;
        vec_next.y = sd_reg[6].py;
        vec_next.z = delta7_reg;
        if (delta7_reg >= rtw_pkg::QTR_TURN && delta7_reg < rtw_pkg::TQTR_TURN)
        begin
            vec_next.x = -sd_reg[6].px;
            vec_next.y = -sd_reg[6].py;
            vec_next.z = delta7_reg - rtw_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k = k + 1)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k = k + 1)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= side0;
            for (int k = 1; k < DEPTH; k = k + 1)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
            p1_reg <= in_vx * rtw_pkg::INV_GAIN;
            p2_reg <= rad * inv_max_length;
            w3_reg <= (wide > {11'd0, rtw_pkg::WEIGHT_MAX}) ? rtw_pkg::WEIGHT_MAX : wide[23:0];
            pc_reg <= w3_reg * rtw_pkg::DIV45_M30;
            w4_reg <= w3_reg;
            w5_reg <= w4_reg;
            if (d0[25])
            begin
                c5_reg <= c0 - 19'd1;
                d5_reg <= d0[5:0] + rtw_pkg::DIV45;
            end
            else
            begin
                c5_reg <= c0;
                d5_reg <= d0[5:0];
            end
            aw6_reg    <= aw_full[26:0];
            bc6_reg    <= b_reg * c5_reg;
            bd6_reg    <= b_reg * d5_reg;
            delta7_reg <= neg3_reg ? (32'd0 - mag) : mag;
            vec8_reg   <= vec_next;
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_vec   = vec8_reg;
    assign out_side  = sd_reg[DEPTH-1];

endmodule

>>> rtl/radial_twirl_point_warp_core.sv
// Top level of the radial twirl point warp: input stage, two CORDIC cell
// chains, twirl angle pipeline and output scaling. Depends on rtw_pkg.

// Each point is taken to polar form by a chain of vectoring CORDIC cells
// (hue = its angle, Q0.16 turns), then rotated by rotation_degrees times a
// radius-dependent weight through a chain of rotating cells, and scaled back
// to Q12.4 with saturation. The block is a fully pipelined row of cells: it
// takes one point per clock while in_stall is low; each chain holds
// min(CORDIC_STAGES, 24) cells. The whole pipeline advances together; it
// holds only while a result sits in the output register and out_stall is
// high, and then in_stall is raised. cfg_ready is always high; write
// registers only while no transaction is in flight.
module radial_twirl_point_warp_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] warped_x,
    output logic signed [15:0] warped_y,
    output logic [15:0]        hue,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CW     = rtw_pkg::CW;
    localparam int STAGES = (CORDIC_STAGES > rtw_pkg::TABLE_LEN) ?
                            rtw_pkg::TABLE_LEN : CORDIC_STAGES;
    localparam int SW     = CW - 6;
    localparam logic signed [31:0] SAT_HI = (32'sd1 <<< (COORD_WIDTH - 1)) - 32'sd1;
    localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;

    logic                adv;
    logic signed [31:0]  rotation_degrees_reg;
    logic [23:0]         inv_max_length_reg;

    // input stage
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 s0_valid_reg;
    rtw_pkg::rtw_vec_t    s0_vec_reg;
    rtw_pkg::rtw_side_t   s0_side_reg;

    // chains
    logic               vv   [0:STAGES];
    rtw_pkg::rtw_vec_t  vvec [0:STAGES];
    rtw_pkg::rtw_side_t vsd  [0:STAGES];
    logic               rv   [0:STAGES];
    rtw_pkg::rtw_vec_t  rvec [0:STAGES];
    rtw_pkg::rtw_side_t rsd  [0:STAGES];

    // output stages
    logic                    o1_valid_reg;
    logic signed [CW+31:0]   mx_reg;
    logic signed [CW+31:0]   my_reg;
    rtw_pkg::rtw_side_t      o1_side_reg;
    logic signed [CW+31:0]   rnd_x;
    logic signed [CW+31:0]   rnd_y;
    logic signed [31:0]      ex;
    logic signed [31:0]      ey;
    logic signed [31:0]      sx;
    logic signed [31:0]      sy;
    logic                    out_valid_reg;
    logic [15:0]             wx_reg;
    logic [15:0]             wy_reg;
    logic [15:0]             hue_reg;

    // Advance everything unless a finished result is being held.
    assign adv       = ~out_valid_reg | ~out_stall;
    assign in_stall  = ~adv;
    assign cfg_ready = 1'b1;

    // Configuration registers; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_degrees_reg <= 32'sd0;
            inv_max_length_reg   <= 24'd41943;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rtw_pkg::REG_ROTATION: rotation_degrees_reg <= cfg_data;
                rtw_pkg::REG_INV_LEN:  inv_max_length_reg   <= cfg_data[23:0];
                default:               ;
            endcase
        end
    end

    // Q12.4 to Q12.12; reflect the left half plane so vectoring converges.
    always_comb
    begin
        px = {{(CW-24){point_x[15]}}, point_x, 8'h00};
        py = {{(CW-24){point_y[15]}}, point_y, 8'h00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_vec_reg.x     <= point_x[15] ? -px : px;
            s0_vec_reg.y     <= point_x[15] ? -py : py;
            s0_vec_reg.z     <= point_x[15] ? rtw_pkg::HALF_TURN : 32'd0;
            s0_side_reg.px   <= px;
            s0_side_reg.py   <= py;
            s0_side_reg.zero <= (point_x == 16'sd0) && (point_y == 16'sd0);
            s0_side_reg.hue  <= 16'd0;
        end
    end

    assign vv[0]   = s0_valid_reg;
    assign vvec[0] = s0_vec_reg;
    assign vsd[0]  = s0_side_reg;

    // Vectoring chain: z accumulates the polar angle, x the gained radius.
    genvar g;
    generate
        for (g = 0; g < STAGES; g = g + 1)
        begin : g_vec
            rtw_cordic_cell #(
                .STAGE     (g),
                .VECTORING (1'b1)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .in_valid  (vv[g]),
                .in_vec    (vvec[g]),
                .in_side   (vsd[g]),
                .out_valid (vv[g+1]),
                .out_vec   (vvec[g+1]),
                .out_side  (vsd[g+1])
            );
        end
    endgenerate

    // Weight and twirl angle; hands the original point and angle onward.
    rtw_twirl_angle u_angle (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .rotation_degrees (rotation_degrees_reg),
        .inv_max_length   (inv_max_length_reg),
        .in_valid         (vv[STAGES]),
        .in_vx            (vvec[STAGES].x),
        .in_phase         (vvec[STAGES].z),
        .in_side          (vsd[STAGES]),
        .out_valid        (rv[0]),
        .out_vec          (rvec[0]),
        .out_side         (rsd[0])
    );

    // Rotation chain: drive z to zero while turning the point.
    generate
        for (g = 0; g < STAGES; g = g + 1)
        begin : g_rot
            rtw_cordic_cell #(
                .STAGE     (g),
                .VECTORING (1'b0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .in_valid  (rv[g]),
                .in_vec    (rvec[g]),
                .in_side   (rsd[g]),
                .out_valid (rv[g+1]),
                .out_vec   (rvec[g+1]),
                .out_side  (rsd[g+1])
            );
        end
    endgenerate

    // Remove the CORDIC gain, then round back to Q12.4 and saturate.
    always_comb
    begin
        rnd_x = mx_reg + $signed({{(CW-6){1'b0}}, 1'b1, 37'd0});
        rnd_y = my_reg + $signed({{(CW-6){1'b0}}, 1'b1, 37'd0});
        ex    = {{(32-SW){rnd_x[CW+31]}}, rnd_x[CW+31:38]};
        ey    = {{(32-SW){rnd_y[CW+31]}}, rnd_y[CW+31:38]};
        sx    = (ex > SAT_HI) ? SAT_HI : ((ex < SAT_LO) ? SAT_LO : ex);
        sy    = (ey > SAT_HI) ? SAT_HI : ((ey < SAT_LO) ? SAT_LO : ey);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            o1_valid_reg  <= rv[STAGES];
            out_valid_reg <= o1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg      <= rvec[STAGES].x * rtw_pkg::INV_GAIN;
            my_reg      <= rvec[STAGES].y * rtw_pkg::INV_GAIN;
            o1_side_reg <= rsd[STAGES];
            // origin maps to origin with hue zero
            wx_reg      <= o1_side_reg.zero ? 16'd0 : sx[15:0];
            wy_reg      <= o1_side_reg.zero ? 16'd0 : sy[15:0];
            hue_reg     <= o1_side_reg.zero ? 16'd0 : o1_side_reg.hue;
        end
    end

    assign out_valid = out_valid_reg;
    assign warped_x  = wx_reg;
    assign warped_y  = wy_reg;
    assign hue       = hue_reg;

endmodule

>>> rtl/rtw_checker.sv
// Port-level checker for the radial twirl point warp core, with its bind.
// Depends only on the top level's ports.
module rtw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] warped_x,
    input logic [15:0] hue,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(warped_x) && $stable(hue))
        else $error("stalled result changed");

    // input side backs up only behind a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall without held result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind radial_twirl_point_warp_core rtw_checker u_rtw_checker (.*);

>>> test/radial_twirl_point_warp_core_tb.sv
// Testbench for radial_twirl_point_warp_core: directed and random points through
// the twirl warp, checked against a local CORDIC predictor. Depends on rtw_pkg.
`timescale 1ns / 1ps

module radial_twirl_point_warp_core_tb;

    // register indexes with no register behind them
    localparam logic [1:0] REG_UNUSED_2  = 2'd2;
    localparam logic [1:0] REG_UNUSED_3  = 2'd3;

    localparam int NUM_STAGES = 16;      // CORDIC_STAGES of the instance
    localparam int PIPE_DEPTH = 2 * NUM_STAGES + 11;

    // per-stage arctangents, Q0.32 turns
    localparam logic [31:0] ATAN_TURNS [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [15:0] wx;
        logic [15:0] wy;
        logic [15:0] hue;
    } warp_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] warped_x;
    logic signed [15:0] warped_y;
    logic [15:0]        hue;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    // predictor copy of the registers
    logic signed [31:0] twirl_deg;
    logic [23:0]        inv_len;

    warp_t warp_pending[$];
    int    error_count;
    int    points_sent;
    int    results_seen;
    bit    quiet_sender;     // no gaps on the input side
    bit    quiet_receiver;   // no stalls on the output side
    int    stall_left;

    radial_twirl_point_warp_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .warped_x  (warped_x),
        .warped_y  (warped_y),
        .hue       (hue),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Compute the warped point and hue of one input point.
    function automatic warp_t twirl_point(logic signed [15:0] x, logic signed [15:0] y);
        longint px, py, vx, vy, dx, dy, rx, ry, z;
        longint radius, ratio, weight, deg, ox, oy;
        longint unsigned mag;
        logic [31:0] phase, delta;
        logic [32:0] hue_round;
        warp_t r;
        px = longint'(x) * 256;
        py = longint'(y) * 256;
        if (px == 0 && py == 0)
        begin
            r = '0;
            return r;
        end
        // vectoring: fold the left half plane onto the right first
        vx = px;
        vy = py;
        phase = 32'h0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            phase = rtw_pkg::HALF_TURN;
        end
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx += dx; vy -= dy; phase = phase + ATAN_TURNS[i];
            end
            else
            begin
                vx -= dx; vy += dy; phase = phase - ATAN_TURNS[i];
            end
        end
        hue_round = {1'b0, phase} + 33'h8000;
        r.hue = hue_round[31:16];

        // weight = 1 + 4 * radius / max_length, saturated at 255
        radius = (vx * longint'(rtw_pkg::INV_GAIN)) >>> 30;
        if (radius < 0)
            radius = 0;
        ratio = (radius * longint'(inv_len)) >>> 20;
        weight = 65536 + 4 * ratio;
        if (weight > longint'(rtw_pkg::WEIGHT_MAX))
            weight = longint'(rtw_pkg::WEIGHT_MAX);

        deg = longint'(twirl_deg);
        mag = longint'(deg < 0 ? -deg : deg);
        mag = mag * longint'(weight) * 64'd32 / 64'd45;
        delta = mag[31:0];
        if (deg < 0)
            delta = 32'h0 - delta;

        // rotation: bring the angle into the right half plane
        rx = px;
        ry = py;
        if (delta >= rtw_pkg::QTR_TURN && delta < rtw_pkg::TQTR_TURN)
        begin
            rx = -rx;
            ry = -ry;
            delta = delta - rtw_pkg::HALF_TURN;
        end
        z = longint'($signed(delta));
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            dx = ry >>> i;
            dy = rx >>> i;
            if (z >= 0)
            begin
                rx -= dx; ry += dy; z -= longint'(ATAN_TURNS[i]);
            end
            else
            begin
                rx += dx; ry -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        ox = (rx * longint'(rtw_pkg::INV_GAIN) + (64'sd1 <<< 37)) >>> 38;
        oy = (ry * longint'(rtw_pkg::INV_GAIN) + (64'sd1 <<< 37)) >>> 38;
        if (ox > 32767) ox = 32767;
        if (ox < -32768) ox = -32768;
        if (oy > 32767) oy = 32767;
        if (oy < -32768) oy = -32768;
        r.wx = ox[15:0];
        r.wy = oy[15:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one point; hold the payload until accepted, then predict it.
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        do
            @(posedge clk);
        while (in_stall);
        warp_pending = {warp_pending, twirl_point(x, y)};
        points_sent++;
    endtask

    // Lower valid and hold off until every expected result is back.
    task automatic drain();
        in_valid <= 1'b0;
        while (warp_pending.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; leave cfg_valid for end_config to drop.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == rtw_pkg::REG_ROTATION)
            twirl_deg = data;
        else if (idx == rtw_pkg::REG_INV_LEN)
            inv_len = data[23:0];
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(input int count);
        logic signed [15:0] x, y;
        int mode;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else if (mode < 8)
            begin
                // points well inside max_length, where the weight varies
                x = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
                y = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
            end
            else
            begin
                // points on or near the axes and the origin
                x = ($urandom_range(0, 1) != 0) ? 16'sd0 : 16'($urandom);
                y = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 2)) - 16'sd1
                                                : 16'($urandom);
            end
            send_point(x, y);
        end
    endtask

    // Directed points at reset settings: origin, extremes, axes, left half plane.
    task automatic test_reset_defaults();
        send_point(16'sd0, 16'sd0);
        send_point(16'sh7FFF, 16'sh7FFF);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sh7FFF, -16'sd32768);
        send_point(-16'sd32768, 16'sh7FFF);
        send_point(-16'sd100, 16'sd0);
        send_point(-16'sd100, 16'sd1);
        send_point(-16'sd100, -16'sd1);
        send_point(16'sd0, 16'sd100);
        send_point(16'sd0, -16'sd100);
        send_point(16'sd1, 16'sd0);
        send_point(-16'sd1, -16'sd1);
        drain();
    endtask

    // Quarter and half turns, negative and extreme angles, extreme lengths.
    task automatic test_twirl_angles();
        write_reg(rtw_pkg::REG_ROTATION, 32'd90 * 32'd256);
        end_config();
        send_point(16'sd160, 16'sd0);
        send_point(16'sd0, 16'sd160);
        send_point(16'sh7FFF, 16'sd0);
        send_point(-16'sd32768, 16'sd0);
        drain();
        write_reg(rtw_pkg::REG_ROTATION, 32'd180 * 32'd256);
        write_reg(rtw_pkg::REG_INV_LEN, 32'h00FFFFFF);
        end_config();
        send_point(16'sd160, 16'sd160);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd3, -16'sd5);
        drain();
        write_reg(rtw_pkg::REG_ROTATION, 32'h80000000);
        write_reg(rtw_pkg::REG_INV_LEN, 32'h0);
        end_config();
        send_point(16'sd1000, -16'sd1000);
        send_point(16'sh7FFF, 16'sh7FFF);
        drain();
        write_reg(rtw_pkg::REG_ROTATION, 32'h7FFFFFFF);
        end_config();
        send_point(-16'sd1000, 16'sd1000);
        send_point(16'sd0, 16'sd0);
        drain();
    endtask

    // Writes to unused indexes must leave both registers untouched.
    task automatic test_unused_index();
        write_reg(rtw_pkg::REG_ROTATION, -32'sd45 * 32'sd256);
        write_reg(rtw_pkg::REG_INV_LEN, 32'd41943);
        write_reg(REG_UNUSED_2, 32'hFFFFFFFF);
        write_reg(REG_UNUSED_3, 32'h12345678);
        end_config();
        send_point(16'sd800, 16'sd300);
        send_point(-16'sd800, -16'sd300);
        drain();
    endtask

    // Random points across several settings, extremes among them.
    task automatic test_random_settings();
        logic [31:0] rot_set [0:6];
        logic [23:0] len_set [0:6];
        rot_set = '{32'd0, 32'd30 * 32'd256, 32'h7FFFFFFF, 32'h80000000,
                    32'hFFFFFF00, 32'd0, 32'd0};
        len_set = '{24'd41943, 24'hFFFFFF, 24'd0, 24'd41943,
                    24'd1000, 24'd0, 24'd0};
        for (int p = 0; p < 7; p++)
        begin
            if (p >= 5)
            begin
                rot_set[p] = $urandom;
                len_set[p] = 24'($urandom);
            end
            write_reg(rtw_pkg::REG_ROTATION, rot_set[p]);
            write_reg(rtw_pkg::REG_INV_LEN, {8'h00, len_set[p]});
            end_config();
            // one phase with no gaps and one with no stalls
            quiet_sender   = (p == 2);
            quiet_receiver = (p == 4);
            send_random(245);
            drain();
        end
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    // Output side: random stall bursts, then check each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (warp_pending.size() == 0)
                begin
                    $error("unexpected result x=%0d y=%0d hue=%0d", warped_x, warped_y, hue);
                    error_count++;
                end
                else
                begin
                    warp_t exp_w;
                    exp_w = warp_pending.pop_front();
                    if (warped_x !== exp_w.wx)
                    begin
                        $error("warped_x expected %0d got %0d",
                               $signed(exp_w.wx), warped_x);
                        error_count++;
                    end
                    if (warped_y !== exp_w.wy)
                    begin
                        $error("warped_y expected %0d got %0d",
                               $signed(exp_w.wy), warped_y);
                        error_count++;
                    end
                    if (hue !== exp_w.hue)
                    begin
                        $error("hue expected %0d got %0d", exp_w.hue, hue);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_receiver && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_gap();
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Guard against a hung handshake.
    initial
    begin
        #5ms;
        $display("radial_twirl_point_warp_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        point_x        = '0;
        point_y        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        twirl_deg      = '0;
        inv_len        = 24'd41943;
        error_count    = 0;
        points_sent    = 0;
        results_seen   = 0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_twirl_angles();
        test_unused_index();
        test_random_settings();

        drain();
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (warp_pending.size() != 0)
        begin
            $error("%0d results never arrived", warp_pending.size());
            error_count++;
        end
        $display("Sent %0d points and checked %0d warped results over 13 register settings,",
                 points_sent, results_seen);
        $display("including extreme angles, extreme lengths and unused register indexes.");
        if (error_count == 0)
            $display("radial_twirl_point_warp_core_tb: PASS");
        else
            $display("radial_twirl_point_warp_core_tb: FAIL");
        $finish;
    end

endmodule
